// ===== rtl/dpmr_hid_pkg.sv =====
// Shared types, constants and constant tables for the dPMR header ID decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package dpmr_hid_pkg;

  // Frame and text layout
  localparam int unsigned FrameW   = 48;
  localparam int unsigned CrcW     = 7;
  localparam int unsigned CrcBits  = 41;
  localparam int unsigned IdPartW  = 12;
  localparam int unsigned AddrW    = 24;
  localparam int unsigned TextW    = 56;
  localparam logic [CrcW-1:0] CrcPoly = 7'h09;

  // Address split: addr = quo * 14641 + rem, quo < 1146, rem < 14641
  localparam int unsigned DivHi      = 14641;
  localparam int unsigned HiShift    = 38;
  localparam int unsigned QuoW       = 11;
  localparam int unsigned RemW       = 14;
  localparam logic [24:0] RecipHi    =
    25'(((64'd1 << HiShift) + 64'(DivHi) - 64'd1) / 64'(DivHi));

  // Hundreds digit of quo: quo / 100
  localparam int unsigned DivHund    = 100;
  localparam int unsigned HundShift  = 18;
  localparam logic [11:0] RecipHund  =
    12'(((64'd1 << HundShift) + 64'(DivHund) - 64'd1) / 64'(DivHund));

  // Upper base-11 pair of rem: rem / 121
  localparam int unsigned DivSq      = 121;
  localparam int unsigned SqShift    = 21;
  localparam logic [14:0] RecipSq    =
    15'(((64'd1 << SqShift) + 64'(DivSq) - 64'd1) / 64'(DivSq));

  // Character codes
  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharStar = 8'h2A;
  localparam logic [3:0] DigitTen = 4'd10;

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [TextW-1:0] text_t;

  typedef enum logic [1:0] {
    PartCalled  = 2'd0,
    PartCalling = 2'd1,
    PartUnknown = 2'd2
  } part_kind_e;

  typedef enum logic [1:0] {
    HalfUnknown = 2'd0,
    HalfCalled  = 2'd1,
    HalfCalling = 2'd2
  } half_e;

  // Per-frame check results
  typedef struct packed {
    logic                crc_ok;
    logic                usable;
    logic                good;
    logic [1:0]          fnum;
    logic [IdPartW-1:0]  id_part;
  } frame_info_t;

  // Per-word side information carried alongside the radix pipeline
  typedef struct packed {
    part_kind_e  kind;
    logic        id_good;
    logic [1:0]  crc;
    logic [3:0]  fnum;
  } meta_t;

  // CRC is linear: column b is the remainder left by a lone one in received bit b
  function automatic logic [CrcBits-1:0][CrcW-1:0] build_crc_cols();
    logic [CrcBits-1:0][CrcW-1:0] cols;
    logic [CrcW-1:0]              r;
    logic                         fb;
    for (int b = 0; b < CrcBits; b++) begin
      r = '0;
      for (int i = 0; i < CrcBits; i++) begin
        fb = r[CrcW-1] ^ (i == b);
        r  = {r[CrcW-2:0], 1'b0};
        if (fb) begin
          r = r ^ CrcPoly;
        end
      end
      cols[b] = r;
    end
    return cols;
  endfunction

  localparam logic [CrcBits-1:0][CrcW-1:0] CrcCols = build_crc_cols();

  // Two decimal digits {tens, ones} of a 7-bit value
  function automatic logic [127:0][7:0] build_dec_split();
    logic [127:0][7:0] t;
    for (int i = 0; i < 128; i++) begin
      t[i] = {4'(i / 10), 4'(i % 10)};
    end
    return t;
  endfunction

  // Two base-11 digits {high, low} of a 7-bit value
  function automatic logic [127:0][7:0] build_b11_split();
    logic [127:0][7:0] t;
    for (int i = 0; i < 128; i++) begin
      t[i] = {4'(i / 11), 4'(i % 11)};
    end
    return t;
  endfunction

  localparam logic [127:0][7:0] DecSplit = build_dec_split();
  localparam logic [127:0][7:0] B11Split = build_b11_split();

  // Digit to ASCII: ten shows as '*', others as '0' + digit
  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d == DigitTen) begin
      c = CharStar;
    end else begin
      c = CharZero + {4'b0000, d};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/dpmr_hid_frame_chk.sv =====
// Per-frame check: CRC-7 over received bits 0..40, frame number, ID bits.
// Depends on dpmr_hid_pkg.
`default_nettype none

module dpmr_hid_frame_chk (
  input  logic [47:0]               frame_i,
  input  logic [1:0]                cw_ok_i,
  output dpmr_hid_pkg::frame_info_t info_o
);
  import dpmr_hid_pkg::*;

  logic [CrcW-1:0] crc_calc;
  logic            crc_ok;

  // XOR of the column of every set data bit; received bit b is frame bit 47-b
  always_comb begin
    crc_calc = '0;
    for (int b = 0; b < CrcBits; b++) begin
      if (frame_i[FrameW-1-b]) begin
        crc_calc = crc_calc ^ CrcCols[b];
      end
    end
  end

  assign crc_ok = (crc_calc == frame_i[CrcW-1:0]);

  assign info_o.crc_ok  = crc_ok;
  assign info_o.usable  = crc_ok | cw_ok_i[1];
  assign info_o.good    = crc_ok | (cw_ok_i == 2'b11);
  assign info_o.fnum    = frame_i[47:46];
  assign info_o.id_part = frame_i[45:34];

endmodule

`default_nettype wire

// ===== rtl/dpmr_hid_radix.sv =====
// Address to seven ASCII digits, mixed radix (10,10,11,11,11,11 steps).
// Three register stages of reciprocal multiplies and small tables; uses dpmr_hid_pkg.
`default_nettype none

module dpmr_hid_radix (
  input  logic                clk_i,
  input  logic                adv_i,
  input  dpmr_hid_pkg::addr_t addr_i,
  output dpmr_hid_pkg::text_t text_o
);
  import dpmr_hid_pkg::*;

  // Stage 1 (combinational on input): quo = addr / 14641
  logic [48:0]     s1_prod;
  logic [QuoW-1:0] s1_quo;

  assign s1_prod = 49'(addr_i) * 49'(RecipHi);
  assign s1_quo  = s1_prod[HiShift +: QuoW];

  // Stage 2: rem = addr - quo * 14641, hundreds digit = quo / 100
  addr_t           s2_addr_q;
  logic [QuoW-1:0] s2_quo_q;
  logic [24:0]     s2_back;
  logic [23:0]     s2_diff;
  logic [RemW-1:0] s2_rem;
  logic [22:0]     s2_hprod;
  logic [3:0]      s2_d0;

  assign s2_back  = 25'(s2_quo_q) * 25'(DivHi);
  assign s2_diff  = s2_addr_q - s2_back[23:0];
  assign s2_rem   = s2_diff[RemW-1:0];
  assign s2_hprod = 23'(s2_quo_q) * 23'(RecipHund);
  assign s2_d0    = s2_hprod[HundShift +: 4];

  // Stage 3: low two decimals of quo, and rem / 121
  logic [RemW-1:0] s3_rem_q;
  logic [QuoW-1:0] s3_quo_q;
  logic [3:0]      s3_d0_q;
  logic [QuoW-1:0] s3_back;
  logic [QuoW-1:0] s3_diff;
  logic [6:0]      s3_lowq;
  logic [28:0]     s3_pprod;
  logic [6:0]      s3_pair;

  assign s3_back  = 11'(s3_d0_q) * 11'(DivHund);
  assign s3_diff  = s3_quo_q - s3_back;
  assign s3_lowq  = s3_diff[6:0];
  assign s3_pprod = 29'(s3_rem_q) * 29'(RecipSq);
  assign s3_pair  = s3_pprod[SqShift +: 7];

  // Stage 4: rem % 121, table lookups, characters
  logic [RemW-1:0] s4_rem_q;
  logic [3:0]      s4_d0_q;
  logic [6:0]      s4_lowq_q;
  logic [6:0]      s4_pair_q;
  logic [RemW-1:0] s4_back;
  logic [RemW-1:0] s4_diff;
  logic [6:0]      s4_low;
  logic [7:0]      s4_dec;
  logic [7:0]      s4_hi11;
  logic [7:0]      s4_lo11;

  assign s4_back = 14'(s4_pair_q) * 14'(DivSq);
  assign s4_diff = s4_rem_q - s4_back;
  assign s4_low  = s4_diff[6:0];
  assign s4_dec  = DecSplit[s4_lowq_q];
  assign s4_hi11 = B11Split[s4_pair_q];
  assign s4_lo11 = B11Split[s4_low];

  assign text_o = {digit_char(s4_d0_q),
                   digit_char(s4_dec[7:4]),  digit_char(s4_dec[3:0]),
                   digit_char(s4_hi11[7:4]), digit_char(s4_hi11[3:0]),
                   digit_char(s4_lo11[7:4]), digit_char(s4_lo11[3:0])};

  // Stage registers, payload only
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s2_addr_q <= addr_i;
      s2_quo_q  <= s1_quo;
      s3_rem_q  <= s2_rem;
      s3_quo_q  <= s2_quo_q;
      s3_d0_q   <= s2_d0;
      s4_rem_q  <= s3_rem_q;
      s4_d0_q   <= s3_d0_q;
      s4_lowq_q <= s3_lowq;
      s4_pair_q <= s3_pair;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dpmr_hid_frame_chk_pair.sv =====
// Checks both frames of a header pair and builds the 24-bit address.
// Depends on dpmr_hid_pkg and dpmr_hid_frame_chk.
`default_nettype none

module dpmr_hid_frame_chk_pair (
  input  logic [47:0]               first_i,
  input  logic [47:0]               second_i,
  input  logic [1:0]                ok_first_i,
  input  logic [1:0]                ok_second_i,
  output dpmr_hid_pkg::addr_t       addr_o,
  output dpmr_hid_pkg::meta_t       meta_o
);
  import dpmr_hid_pkg::*;

  frame_info_t info0;
  frame_info_t info1;
  logic        is_called;
  logic        is_calling;

  dpmr_hid_frame_chk u_chk0 (
    .frame_i (first_i),
    .cw_ok_i (ok_first_i),
    .info_o  (info0)
  );

  dpmr_hid_frame_chk u_chk1 (
    .frame_i (second_i),
    .cw_ok_i (ok_second_i),
    .info_o  (info1)
  );

  assign addr_o = {info0.id_part, info1.id_part};

  // Half selection: called takes priority over calling
  assign is_called  = (info0.usable && (info0.fnum == 2'd0)) ||
                      (info1.usable && (info1.fnum == 2'd1));
  assign is_calling = (info0.usable && (info0.fnum == 2'd2)) ||
                      (info1.usable && (info1.fnum == 2'd3));

  always_comb begin
    meta_o.id_good = info0.good & info1.good;
    meta_o.crc     = {info0.crc_ok, info1.crc_ok};
    meta_o.fnum    = {info0.fnum, info1.fnum};
    if (is_called) begin
      meta_o.kind = PartCalled;
    end else if (is_calling) begin
      meta_o.kind = PartCalling;
    end else begin
      meta_o.kind = PartUnknown;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dpmr_cch_header_id_decoder_top.sv =====
// Top level of the dPMR control-channel header ID decoder.
// Depends on dpmr_hid_pkg, dpmr_hid_frame_chk_pair and dpmr_hid_radix.
//
//   channel | handshake              | word
//   --------+------------------------+--------------------------------------------
//   in      | in_valid_i, in_stall_o | cch_first/second_i, codeword_ok_first/second_i
//   out     | out_valid_o,out_stall_i| part_kind, flags, texts, expected_half, crc, fnum
//
// One word per cycle unless a stalled result holds the stages; out_valid_o rises
// after the input register, three radix-conversion stages and the result register.
// The stages move together; a stalled result holds every stage and raises in_stall_o.
// Reset clears the stage valid bits, both ID texts, their flags and the expected half.
`default_nettype none

module dpmr_cch_header_id_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [47:0] cch_first_i,
  input  logic [47:0] cch_second_i,
  input  logic [1:0]  codeword_ok_first_i,
  input  logic [1:0]  codeword_ok_second_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  part_kind_o,
  output logic        called_valid_o,
  output logic        calling_valid_o,
  output logic [55:0] called_text_o,
  output logic [55:0] calling_text_o,
  output logic [1:0]  expected_half_o,
  output logic [1:0]  crc_flags_o,
  output logic [3:0]  frame_numbers_o
);
  import dpmr_hid_pkg::*;

  // Pipeline advance: everything moves unless a held result is stalled
  logic adv;
  logic out_valid_q;

  assign adv        = ~(out_valid_q & out_stall_i);
  assign in_stall_o = ~adv;

  // Input register
  logic [47:0] s1_first_q;
  logic [47:0] s1_second_q;
  logic [1:0]  s1_ok0_q;
  logic [1:0]  s1_ok1_q;
  logic [3:0]  vld_q;          // stages 1..4 valid

  addr_t s1_addr;
  meta_t s1_meta;
  meta_t s2_meta_q;
  meta_t s3_meta_q;
  meta_t s4_meta_q;
  text_t s4_text;

  dpmr_hid_frame_chk_pair u_chk (
    .first_i     (s1_first_q),
    .second_i    (s1_second_q),
    .ok_first_i  (s1_ok0_q),
    .ok_second_i (s1_ok1_q),
    .addr_o      (s1_addr),
    .meta_o      (s1_meta)
  );

  dpmr_hid_radix u_radix (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .addr_i (s1_addr),
    .text_o (s4_text)
  );

  // Payload stages
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_first_q  <= cch_first_i;
      s1_second_q <= cch_second_i;
      s1_ok0_q    <= codeword_ok_first_i;
      s1_ok1_q    <= codeword_ok_second_i;
      s2_meta_q   <= s1_meta;
      s3_meta_q   <= s2_meta_q;
      s4_meta_q   <= s3_meta_q;
    end
  end

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q       <= {vld_q[2:0], in_valid_i};
      out_valid_q <= vld_q[3];
    end
  end

  // Result register: per-word fields
  part_kind_e kind_q;
  logic [1:0] crc_q;
  logic [3:0] fnum_q;

  always_ff @(posedge clk_i) begin
    if (adv && vld_q[3]) begin
      kind_q <= s4_meta_q.kind;
      crc_q  <= s4_meta_q.crc;
      fnum_q <= s4_meta_q.fnum;
    end
  end

  // Decoder state, updated as each word leaves stage 4
  text_t called_text_q;
  text_t calling_text_q;
  logic  called_ok_q;
  logic  calling_ok_q;
  half_e half_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      called_text_q  <= '0;
      calling_text_q <= '0;
      called_ok_q    <= 1'b0;
      calling_ok_q   <= 1'b0;
      half_q         <= HalfUnknown;
    end else if (adv && vld_q[3]) begin
      case (s4_meta_q.kind)
        PartCalled: begin
          called_text_q <= s4_text;
          called_ok_q   <= s4_meta_q.id_good;
          half_q        <= HalfCalling;
        end
        PartCalling: begin
          calling_text_q <= s4_text;
          calling_ok_q   <= s4_meta_q.id_good;
          half_q         <= HalfCalled;
        end
        default: begin
          called_ok_q  <= 1'b0;
          calling_ok_q <= 1'b0;
          case (half_q)
            HalfCalled:  half_q <= HalfCalling;
            HalfCalling: half_q <= HalfCalled;
            default:     half_q <= HalfUnknown;
          endcase
        end
      endcase
    end
  end

  // Outputs
  assign out_valid_o     = out_valid_q;
  assign part_kind_o     = kind_q;
  assign called_valid_o  = called_ok_q;
  assign calling_valid_o = calling_ok_q;
  assign called_text_o   = called_text_q;
  assign calling_text_o  = calling_text_q;
  assign expected_half_o = half_q;
  assign crc_flags_o     = crc_q;
  assign frame_numbers_o = fnum_q;

endmodule

`default_nettype wire

// ===== tb/dpmr_cch_header_id_decoder_top_tb.sv =====
// Self-checking testbench for the dPMR control-channel header ID decoder.
// Depends directly on dpmr_hid_pkg and dpmr_cch_header_id_decoder_top.
`default_nettype none

module dpmr_cch_header_id_decoder_top_tb;
  import dpmr_hid_pkg::*;

  localparam int unsigned TopWeight   = 1464100;
  localparam int unsigned RandomPairs = 1700;
  localparam int unsigned HoldCycles  = 80;
  localparam int unsigned HoldEvery   = 700;
  localparam int unsigned IdleLimit   = 1000;
  localparam int unsigned TailCycles  = 12;
  localparam int unsigned ReportMax   = 10;

  // One input word: two corrected frames and their codeword flags
  typedef struct packed {
    logic [FrameW-1:0] first;
    logic [FrameW-1:0] second;
    logic [1:0]        ok_first;
    logic [1:0]        ok_second;
  } header_pair_t;

  // One result word
  typedef struct packed {
    part_kind_e kind;
    logic       called_ok;
    logic       calling_ok;
    text_t      called_txt;
    text_t      calling_txt;
    half_e      half;
    logic [1:0] crc;
    logic [3:0] fnum;
  } id_update_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [47:0]       cch_first_i = '0;
  logic [47:0]       cch_second_i = '0;
  logic [1:0]        codeword_ok_first_i = '0;
  logic [1:0]        codeword_ok_second_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [1:0]        part_kind_o;
  logic              called_valid_o;
  logic              calling_valid_o;
  logic [55:0]       called_text_o;
  logic [55:0]       calling_text_o;
  logic [1:0]        expected_half_o;
  logic [1:0]        crc_flags_o;
  logic [3:0]        frame_numbers_o;

  dpmr_cch_header_id_decoder_top dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .cch_first_i          (cch_first_i),
    .cch_second_i         (cch_second_i),
    .codeword_ok_first_i  (codeword_ok_first_i),
    .codeword_ok_second_i (codeword_ok_second_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .part_kind_o          (part_kind_o),
    .called_valid_o       (called_valid_o),
    .calling_valid_o      (calling_valid_o),
    .called_text_o        (called_text_o),
    .calling_text_o       (calling_text_o),
    .expected_half_o      (expected_half_o),
    .crc_flags_o          (crc_flags_o),
    .frame_numbers_o      (frame_numbers_o)
  );

  always #10 clk_i = ~clk_i;

  header_pair_t header_pairs[$];
  id_update_t   id_updates_due[$];

  // Decoder state as the block should hold it
  half_e       half_next = HalfUnknown;
  text_t       called_txt_exp = '0;
  text_t       calling_txt_exp = '0;
  logic        called_strong = 1'b0;
  logic        calling_strong = 1'b0;

  int unsigned words_in = 0;
  int unsigned words_out = 0;
  int unsigned mismatches = 0;
  int unsigned called_seen = 0;
  int unsigned calling_seen = 0;
  int unsigned unknown_seen = 0;
  int unsigned crc_hits = 0;
  int unsigned holds_done = 0;
  logic        in_taken = 1'b0;

  // CRC-7 over received bits 0..40, first received bit first
  function automatic logic [CrcW-1:0] frame_crc(input logic [FrameW-1:0] f);
    logic [CrcW-1:0] r;
    logic            fb;
    r = '0;
    for (int i = 0; i < CrcBits; i++) begin
      fb = r[CrcW-1] ^ f[FrameW-1-i];
      r  = {r[CrcW-2:0], 1'b0};
      if (fb) begin
        r = r ^ CrcPoly;
      end
    end
    return r;
  endfunction

  function automatic logic [7:0] id_char(input int unsigned d);
    logic [7:0] c;
    if (d == 10) begin
      c = CharStar;
    end else begin
      c = 8'(d + 48);
    end
    return c;
  endfunction

  // Mixed radix: two decimal steps, then base 11
  function automatic text_t id_text(input logic [23:0] addr);
    text_t       txt;
    int unsigned rest;
    int unsigned w;
    txt  = '0;
    rest = addr;
    w    = TopWeight;
    for (int i = 0; i < 6; i++) begin
      txt  = {txt[TextW-9:0], id_char(rest / w)};
      rest = rest % w;
      w    = (i < 2) ? w / 10 : w / 11;
    end
    return {txt[TextW-9:0], id_char(rest)};
  endfunction

  // Predict the result of one accepted pair and advance the stored state
  function automatic id_update_t decode_header_pair(input header_pair_t p);
    id_update_t r;
    logic       crc0, crc1, use0, use1, id_good;
    logic [1:0] fn0, fn1;
    logic [23:0] addr;
    crc0    = frame_crc(p.first) == p.first[CrcW-1:0];
    crc1    = frame_crc(p.second) == p.second[CrcW-1:0];
    fn0     = p.first[47:46];
    fn1     = p.second[47:46];
    addr    = {p.first[45:34], p.second[45:34]};
    id_good = (crc0 || p.ok_first == 2'b11) && (crc1 || p.ok_second == 2'b11);
    use0    = crc0 || p.ok_first[1];
    use1    = crc1 || p.ok_second[1];
    if ((use0 && fn0 == 2'd0) || (use1 && fn1 == 2'd1)) begin
      called_txt_exp = id_text(addr);
      called_strong  = id_good;
      half_next      = HalfCalling;
      r.kind         = PartCalled;
    end else if ((use0 && fn0 == 2'd2) || (use1 && fn1 == 2'd3)) begin
      calling_txt_exp = id_text(addr);
      calling_strong  = id_good;
      half_next       = HalfCalled;
      r.kind          = PartCalling;
    end else begin
      called_strong  = 1'b0;
      calling_strong = 1'b0;
      case (half_next)
        HalfCalled:  half_next = HalfCalling;
        HalfCalling: half_next = HalfCalled;
        default:     half_next = HalfUnknown;
      endcase
      r.kind = PartUnknown;
    end
    r.called_ok   = called_strong;
    r.calling_ok  = calling_strong;
    r.called_txt  = called_txt_exp;
    r.calling_txt = calling_txt_exp;
    r.half        = half_next;
    r.crc         = {crc0, crc1};
    r.fnum        = {fn0, fn1};
    return r;
  endfunction

  // Frame with given number and ID part; CRC right or deliberately broken
  function automatic logic [FrameW-1:0] build_frame(input logic [1:0] fnum,
                                                    input logic [11:0] id_part,
                                                    input logic crc_ok);
    logic [FrameW-1:0] f;
    logic [CrcW-1:0]   c;
    f = {fnum, id_part, 27'($urandom), 7'd0};
    c = frame_crc(f);
    f[CrcW-1:0] = crc_ok ? c : c ^ 7'($urandom_range(1, 127));
    return f;
  endfunction

  task automatic queue_pair(input logic [1:0] fn0, input logic [1:0] fn1,
                            input logic [23:0] addr, input logic crc0_ok,
                            input logic crc1_ok, input logic [1:0] ok0,
                            input logic [1:0] ok1);
    header_pair_t p;
    p.first     = build_frame(fn0, addr[23:12], crc0_ok);
    p.second    = build_frame(fn1, addr[11:0], crc1_ok);
    p.ok_first  = ok0;
    p.ok_second = ok1;
    header_pairs.push_back(p);
  endtask

  task automatic log_mismatch(input string msg);
    mismatches++;
    if (mismatches <= ReportMax) begin
      $display("MISMATCH: %s", msg);
    end
  endtask

  // Sender: bursts of words with random gaps; a word holds until taken
  int unsigned  burst_left = 0;
  int unsigned  gap_left = 0;
  header_pair_t next_pair;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (header_pairs.size() > 0) begin
          next_pair = header_pairs.pop_front();
          cch_first_i          <= next_pair.first;
          cch_second_i         <= next_pair.second;
          codeword_ok_first_i  <= next_pair.ok_first;
          codeword_ok_second_i <= next_pair.ok_second;
          in_valid_i           <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      in_taken = 1'b0;
    end
  end

  // Receiver: rotating stall patterns plus a periodic long hold-off
  int unsigned hold_left = 0;
  int unsigned next_hold_at = 400;
  int unsigned stall_tick = 0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (words_in >= next_hold_at) begin
      hold_left    = HoldCycles - 1;
      next_hold_at = next_hold_at + HoldEvery;
      holds_done++;
      out_stall_i <= 1'b1;
    end else begin
      stall_tick++;
      case ((stall_tick / 48) % 4)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 3) == 0);
        2: out_stall_i <= ($urandom_range(0, 4) < 3);
        default: out_stall_i <= (stall_tick % 3 == 0);
      endcase
    end
  end

  // Accepted input word: predict its result
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      id_updates_due.push_back(decode_header_pair({cch_first_i, cch_second_i,
                                                   codeword_ok_first_i,
                                                   codeword_ok_second_i}));
      words_in++;
      in_taken = 1'b1;
    end
  end

  // Accepted result word: compare with the oldest prediction
  id_update_t got, want;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      words_out++;
      got.kind        = part_kind_e'(part_kind_o);
      got.called_ok   = called_valid_o;
      got.calling_ok  = calling_valid_o;
      got.called_txt  = called_text_o;
      got.calling_txt = calling_text_o;
      got.half        = half_e'(expected_half_o);
      got.crc         = crc_flags_o;
      got.fnum        = frame_numbers_o;
      if (id_updates_due.size() == 0) begin
        log_mismatch($sformatf("result word %0d with nothing pending", words_out));
      end else begin
        want = id_updates_due.pop_front();
        case (want.kind)
          PartCalled:  called_seen++;
          PartCalling: calling_seen++;
          default:     unknown_seen++;
        endcase
        crc_hits += want.crc[1] + want.crc[0];
        if (got.kind !== want.kind || got.called_ok !== want.called_ok ||
            got.calling_ok !== want.calling_ok || got.called_txt !== want.called_txt ||
            got.calling_txt !== want.calling_txt || got.half !== want.half ||
            got.crc !== want.crc || got.fnum !== want.fnum) begin
          log_mismatch($sformatf(
            "word %0d exp kind=%0d ok=%b%b called=%h calling=%h half=%0d crc=%b fn=%h",
            words_out, want.kind, want.called_ok, want.calling_ok, want.called_txt,
            want.calling_txt, want.half, want.crc, want.fnum));
          if (mismatches <= ReportMax) begin
            $display("          got kind=%0d ok=%b%b called=%h calling=%h half=%0d crc=%b fn=%h",
                     got.kind, got.called_ok, got.calling_ok, got.called_txt,
                     got.calling_txt, got.half, got.crc, got.fnum);
          end
        end
      end
    end
  end

  // Watchdog: too long without any word moving on either side
  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("Timeout: no word moved for %0d cycles", IdleLimit);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    header_pair_t p;
    logic [23:0]  addr;

    // Directed: every half decision, priorities, strength, digit extremes
    queue_pair(2'd1, 2'd0, 24'h000000, 1'b1, 1'b1, 2'd0, 2'd0);  // unknown from unknown
    p = '0;
    header_pairs.push_back(p);                                   // zero frames: called, all '0'
    p = '1;
    header_pairs.push_back(p);                                   // all ones: calling, ';' lead
    queue_pair(2'd3, 2'd1, 24'd14641000, 1'b0, 1'b1, 2'd0, 2'd0); // called via second, '*' lead
    queue_pair(2'd2, 2'd0, 24'd161050, 1'b1, 1'b0, 2'd3, 2'd1);   // calling via first, weak
    queue_pair(2'd1, 2'd3, 24'hABCDEF, 1'b1, 1'b0, 2'd0, 2'd2);   // calling via codeword flag
    queue_pair(2'd1, 2'd0, 24'h123456, 1'b1, 1'b1, 2'd3, 2'd3);   // unknown, toggles half
    queue_pair(2'd3, 2'd2, 24'h654321, 1'b1, 1'b1, 2'd0, 2'd0);   // unknown, toggles back
    queue_pair(2'd0, 2'd1, 24'h0F0F0F, 1'b0, 1'b0, 2'd1, 2'd0);   // numbers fit but unusable
    queue_pair(2'd0, 2'd3, 24'hF0F0F0, 1'b1, 1'b1, 2'd0, 2'd0);   // called beats calling
    queue_pair(2'd2, 2'd1, 24'h800001, 1'b1, 1'b1, 2'd0, 2'd0);   // called via second wins
    queue_pair(2'd0, 2'd0, 24'h7FFFFE, 1'b0, 1'b0, 2'd3, 2'd3);   // strong by codewords only
    queue_pair(2'd2, 2'd2, 24'h3C3C3C, 1'b0, 1'b0, 2'd2, 2'd3);   // usable but weak
    queue_pair(2'd3, 2'd3, 24'hFFFFFF, 1'b1, 1'b1, 2'd0, 2'd0);   // max address
    queue_pair(2'd0, 2'd2, 24'h000000, 1'b1, 1'b1, 2'd0, 2'd0);   // min address
    queue_pair(2'd3, 2'd2, 24'd16105099, 1'b1, 1'b1, 2'd1, 2'd1); // unknown after called
    queue_pair(2'd2, 2'd3, 24'd16105099, 1'b0, 1'b0, 2'd0, 2'd0); // unusable, unknown

    // Random: mostly well-formed pairs, some raw noise
    for (int n = 0; n < RandomPairs; n++) begin
      if ($urandom_range(0, 3) == 0) begin
        p.first     = 48'({$urandom, $urandom});
        p.second    = 48'({$urandom, $urandom});
        p.ok_first  = 2'($urandom);
        p.ok_second = 2'($urandom);
        header_pairs.push_back(p);
      end else begin
        addr = ($urandom_range(0, 7) == 0) ? 24'($urandom_range(14641000, 16777215))
                                           : 24'($urandom);
        queue_pair(2'($urandom), 2'($urandom), addr, $urandom_range(0, 7) != 0,
                   $urandom_range(0, 7) != 0, 2'($urandom), 2'($urandom));
      end
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (header_pairs.size() != 0 || in_valid_i) begin
      @(negedge clk_i);
    end
    while (id_updates_due.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (TailCycles) @(negedge clk_i);

    $display("Checked %0d result words: %0d called, %0d calling, %0d unknown halves.",
             words_out, called_seen, calling_seen, unknown_seen);
    $display("%0d frames matched CRC; %0d long receiver hold-offs; %0d mismatches.",
             crc_hits, holds_done, mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
